### rtl/core/moed_pkg.sv
// Shared constants and types for the multi-operator edge detector.
`timescale 1ns / 1ps

package moed_pkg;

    localparam int PIX_W      = 8;
    localparam int ROW_OUT_W  = 12;
    localparam int COL_OUT_W  = 10;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 13;
    localparam int MODE_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd2;

    localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 11'd640;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 13'd480;

    localparam logic [MODE_W-1:0] MODE_ROBERTS = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PREWITT = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SOBEL   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SCHARR  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_LAP4    = 3'd4;
    localparam logic [MODE_W-1:0] MODE_LAP8    = 3'd5;

    localparam logic [MODE_W-1:0] MODE_RST = MODE_SOBEL;

    // gradient sums fit 13 bits signed (Scharr reaches +-4080)
    localparam int SUM_W = 13;
    localparam int MAG_W = 14;
    typedef logic signed [SUM_W-1:0] t_sum;
    typedef logic signed [MAG_W-1:0] t_mag;

    localparam t_sum K_TWO   = 13'sd2;
    localparam t_sum K_THREE = 13'sd3;
    localparam t_sum K_FOUR  = 13'sd4;
    localparam t_sum K_EIGHT = 13'sd8;
    localparam t_sum K_TEN   = 13'sd10;

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;
    localparam int CREDIT_W   = 4;

endpackage

### rtl/core/moed_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module moed_ram #(
    parameter int P_WIDTH = 8,
    parameter int P_DEPTH = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(P_DEPTH)-1:0] i_waddr,
    input  logic [P_WIDTH-1:0]         i_wdata,
    input  logic                       i_re,
    input  logic [$clog2(P_DEPTH)-1:0] i_raddr,
    output logic [P_WIDTH-1:0]         o_rdata
);

    logic [P_WIDTH-1:0] r_mem [P_DEPTH];
    logic [P_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/multi_operator_edge_detector_top.sv
// Top level of the streaming 3x3 / 2x2 multi-operator edge detector.
//
//  channel   dir  handshake          payload
//  pixel in  in   i_valid / o_stall  i_pixel_in
//  result    out  o_valid / i_stall  o_pixel_out o_out_row o_out_col o_is_border o_last_of_run
//  config    in   i_cfg_we           i_cfg_index i_cfg_data
//
// One pixel accepted per cycle while o_stall is low; stage 1 and 2 registers lead to the queue.
// A pixel with both an edge and a border result is output as its edge result, then its border result.
// Input stalls when the 8-entry result queue plus in-flight pixels are full.
// Reset clears counters, window and queue and loads 640x480 Sobel; line stores
// are not cleared.
`timescale 1ns / 1ps

module multi_operator_edge_detector_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [moed_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [moed_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [moed_pkg::PIX_W-1:0]        i_pixel_in,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [moed_pkg::PIX_W-1:0]        o_pixel_out,
    output logic [moed_pkg::ROW_OUT_W-1:0]    o_out_row,
    output logic [moed_pkg::COL_OUT_W-1:0]    o_out_col,
    output logic                              o_is_border,
    output logic                              o_last_of_run
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int PW    = moed_pkg::PIX_W;
    localparam int ORW   = moed_pkg::ROW_OUT_W;
    localparam int OCW   = moed_pkg::COL_OUT_W;
    localparam int WW    = moed_pkg::WIDTH_W;
    localparam int HW    = moed_pkg::HEIGHT_W;
    localparam int SW    = moed_pkg::SUM_W;
    localparam int MW    = moed_pkg::MAG_W;
    localparam int FAW   = moed_pkg::FIFO_AW;
    localparam int CRW   = moed_pkg::CREDIT_W;

    typedef struct packed {
        logic [PW-1:0]  edge_pix;
        logic [ORW-1:0] edge_row;
        logic [OCW-1:0] edge_col;
        logic [PW-1:0]  bord_pix;
        logic [ORW-1:0] bord_row;
        logic [OCW-1:0] bord_col;
        logic           has_edge;
        logic           has_border;
    } t_res;

    // configuration
    logic [WW-1:0]                 r_image_width;
    logic [HW-1:0]                 r_image_height;
    logic [moed_pkg::MODE_W-1:0]   r_operator_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width   <= moed_pkg::WIDTH_RST;
            r_image_height  <= moed_pkg::HEIGHT_RST;
            r_operator_mode <= moed_pkg::MODE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                moed_pkg::REG_WIDTH:  r_image_width   <= i_cfg_data[WW-1:0];
                moed_pkg::REG_HEIGHT: r_image_height  <= i_cfg_data[HW-1:0];
                moed_pkg::REG_MODE:   r_operator_mode <= i_cfg_data[moed_pkg::MODE_W-1:0];
                default: ;
            endcase
        end
    end

    logic [COL_W-1:0] w_last;
    logic [ROW_W-1:0] h_last;

    always_comb begin
        if (r_image_width < WW'(2)) begin
            w_last = COL_W'(1);
        end else if (32'(r_image_width) > 32'(MAX_WIDTH)) begin
            w_last = COL_W'(MAX_WIDTH - 1);
        end else begin
            w_last = COL_W'(r_image_width - WW'(1));
        end
        if (r_image_height < HW'(2)) begin
            h_last = ROW_W'(1);
        end else if (32'(r_image_height) > 32'(MAX_HEIGHT)) begin
            h_last = ROW_W'(MAX_HEIGHT - 1);
        end else begin
            h_last = ROW_W'(r_image_height - HW'(1));
        end
    end

    // position counters
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic             in_acc;
    logic             col_last, row_last, is_rob, edge_en, border_en;
    logic             cnt_clear;

    assign in_acc    = i_valid && !o_stall;
    assign col_last  = (r_col == w_last);
    assign row_last  = (r_row == h_last);
    assign is_rob    = (r_operator_mode == moed_pkg::MODE_ROBERTS);
    assign cnt_clear = i_cfg_we && (i_cfg_index == moed_pkg::REG_WIDTH ||
                                    i_cfg_index == moed_pkg::REG_HEIGHT);

    always_comb begin
        if (is_rob) begin
            edge_en   = (r_row != '0) && (r_col != '0);
            border_en = row_last || col_last;
        end else begin
            edge_en   = (r_row > ROW_W'(1)) && (r_col > COL_W'(1));
            border_en = row_last || col_last || (r_row == '0) || (r_col == '0);
        end
        if (col_last) begin
            n_col = '0;
            n_row = row_last ? '0 : r_row + ROW_W'(1);
        end else begin
            n_col = r_col + COL_W'(1);
            n_row = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (cnt_clear) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // stage 1: line store read data arrives
    logic                         r_s1_valid;
    logic [PW-1:0]                r_s1_pix;
    logic [ROW_W-1:0]             r_s1_row;
    logic [COL_W-1:0]             r_s1_col;
    logic [moed_pkg::MODE_W-1:0]  r_s1_mode;
    logic                         r_s1_edge, r_s1_border;

    logic [PW-1:0] older_rd, newer_rd;

    moed_ram #(.P_WIDTH(PW), .P_DEPTH(MAX_WIDTH)) u_older (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_col),
        .i_wdata (newer_rd),
        .i_re    (in_acc),
        .i_raddr (r_col),
        .o_rdata (older_rd)
    );

    moed_ram #(.P_WIDTH(PW), .P_DEPTH(MAX_WIDTH)) u_newer (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_col),
        .i_wdata (r_s1_pix),
        .i_re    (in_acc),
        .i_raddr (r_col),
        .o_rdata (newer_rd)
    );

    logic [PW-1:0] r_win [9];
    logic [PW-1:0] n_win [9];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_win[k*3+0] = r_win[k*3+1];
            n_win[k*3+1] = r_win[k*3+2];
        end
        n_win[2] = older_rd;
        n_win[5] = newer_rd;
        n_win[8] = r_s1_pix;
    end

    moed_pkg::t_sum pa, pb, pc, pd, pe, pf, pg, ph, pi;
    moed_pkg::t_sum gx, gy;
    logic           lap;

    always_comb begin
        pa = SW'(n_win[0]);
        pb = SW'(n_win[1]);
        pc = SW'(n_win[2]);
        pd = SW'(n_win[3]);
        pe = SW'(n_win[4]);
        pf = SW'(n_win[5]);
        pg = SW'(n_win[6]);
        ph = SW'(n_win[7]);
        pi = SW'(n_win[8]);
        lap = 1'b0;
        case (r_s1_mode)
            moed_pkg::MODE_ROBERTS: begin
                gx = pi - pe;
                gy = ph - pf;
            end
            moed_pkg::MODE_PREWITT: begin
                gx = (pa + pd + pg) - (pc + pf + pi);
                gy = (pa + pb + pc) - (pg + ph + pi);
            end
            moed_pkg::MODE_SCHARR: begin
                gx = (moed_pkg::K_THREE * (pc + pi) + moed_pkg::K_TEN * pf)
                   - (moed_pkg::K_THREE * (pa + pg) + moed_pkg::K_TEN * pd);
                gy = (moed_pkg::K_THREE * (pg + pi) + moed_pkg::K_TEN * ph)
                   - (moed_pkg::K_THREE * (pa + pc) + moed_pkg::K_TEN * pb);
            end
            moed_pkg::MODE_LAP4: begin
                gx  = (pb + pd + pf + ph) - moed_pkg::K_FOUR * pe;
                gy  = '0;
                lap = 1'b1;
            end
            moed_pkg::MODE_LAP8: begin
                gx  = (pa + pb + pc + pd + pf + pg + ph + pi) - moed_pkg::K_EIGHT * pe;
                gy  = '0;
                lap = 1'b1;
            end
            default: begin
                gx = (pa + moed_pkg::K_TWO * pd + pg) - (pc + moed_pkg::K_TWO * pf + pi);
                gy = (pa + moed_pkg::K_TWO * pb + pc) - (pg + moed_pkg::K_TWO * ph + pi);
            end
        endcase
    end

    // stage 2: magnitude and saturation
    logic             r_s2_valid;
    moed_pkg::t_sum   r_s2_gx, r_s2_gy;
    logic             r_s2_lap;
    logic [PW-1:0]    r_s2_pix;
    logic [ROW_W-1:0] r_s2_row;
    logic [COL_W-1:0] r_s2_col;
    logic             r_s2_edge, r_s2_border;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= '0;
            end
        end else begin
            r_s1_valid <= in_acc;
            r_s2_valid <= r_s1_valid;
            if (r_s1_valid) begin
                r_win <= n_win;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_pix    <= i_pixel_in;
            r_s1_row    <= r_row;
            r_s1_col    <= r_col;
            r_s1_mode   <= r_operator_mode;
            r_s1_edge   <= edge_en;
            r_s1_border <= border_en;
        end
        if (r_s1_valid) begin
            r_s2_gx     <= gx;
            r_s2_gy     <= gy;
            r_s2_lap    <= lap;
            r_s2_pix    <= r_s1_pix;
            r_s2_row    <= r_s1_row;
            r_s2_col    <= r_s1_col;
            r_s2_edge   <= r_s1_edge;
            r_s2_border <= r_s1_border;
        end
    end

    moed_pkg::t_sum abs_x, abs_y;
    moed_pkg::t_mag mag;
    logic [PW-1:0]  edge_pix;
    t_res           push_ent;
    logic           push, drop;

    always_comb begin
        abs_x = r_s2_gx[SW-1] ? -r_s2_gx : r_s2_gx;
        abs_y = r_s2_gy[SW-1] ? -r_s2_gy : r_s2_gy;
        if (r_s2_lap) begin
            mag = {r_s2_gx[SW-1], r_s2_gx};
        end else begin
            mag = MW'(abs_x) + MW'(abs_y);
        end
        if (mag[MW-1]) begin
            edge_pix = '0;
        end else if (mag > MW'(255)) begin
            edge_pix = '1;
        end else begin
            edge_pix = mag[PW-1:0];
        end
        push_ent.edge_pix   = edge_pix;
        push_ent.edge_row   = ORW'(r_s2_row - ROW_W'(1));
        push_ent.edge_col   = OCW'(r_s2_col - COL_W'(1));
        push_ent.bord_pix   = r_s2_pix;
        push_ent.bord_row   = ORW'(r_s2_row);
        push_ent.bord_col   = OCW'(r_s2_col);
        push_ent.has_edge   = r_s2_edge;
        push_ent.has_border = r_s2_border;
    end

    assign push = r_s2_valid && (r_s2_edge || r_s2_border);
    assign drop = r_s2_valid && !r_s2_edge && !r_s2_border;

    // result queue, one entry per pixel that has results
    t_res           r_fifo [moed_pkg::FIFO_DEPTH];
    logic [FAW-1:0] r_wr_ptr, r_rd_ptr;
    logic [FAW:0]   r_count;
    logic [CRW-1:0] r_credit;
    logic           r_sub;
    t_res           head;
    logic           use_edge, out_acc, pop;

    assign head     = r_fifo[r_rd_ptr];
    assign use_edge = head.has_edge && !r_sub;
    assign o_valid  = (r_count != '0);
    assign out_acc  = o_valid && !i_stall;
    assign pop      = out_acc && o_last_of_run;
    assign o_stall  = (r_credit == '0);

    always_comb begin
        o_pixel_out   = use_edge ? head.edge_pix : head.bord_pix;
        o_out_row     = use_edge ? head.edge_row : head.bord_row;
        o_out_col     = use_edge ? head.edge_col : head.bord_col;
        o_is_border   = !use_edge;
        o_last_of_run = use_edge ? !head.has_border : 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wr_ptr] <= push_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_credit <= CRW'(moed_pkg::FIFO_DEPTH);
            r_sub    <= 1'b0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + FAW'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + FAW'(1);
            end
            r_count  <= r_count + (FAW+1)'(push) - (FAW+1)'(pop);
            r_credit <= r_credit - CRW'(in_acc) + CRW'(pop) + CRW'(drop);
            if (pop) begin
                r_sub <= 1'b0;
            end else if (out_acc) begin
                r_sub <= 1'b1;
            end
        end
    end

endmodule
